// ===== rtl/pstg_pkg.sv =====
package pstg_pkg;

    localparam int MAX_PRODUCERS_DEF = 8;

    localparam logic [3:0]  HDR_LEN       = 4'd12;
    localparam logic [15:0] MIN_LEN_BASIC = 16'd4;
    localparam logic [15:0] MIN_LEN_TS    = 16'd12;
    localparam logic [15:0] SAT16         = 16'hFFFF;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    // configuration register indexes
    localparam logic REG_HEADER_EN    = 1'b0;
    localparam logic REG_TIMESTAMP_EN = 1'b1;

    typedef struct packed {
        logic [15:0] producer;
        logic [15:0] sequence_no;
        logic [15:0] missed;
        logic [31:0] epoch;
        logic [31:0] offset;
    } t_entry;

endpackage

// ===== rtl/producer_sequence_gap_tracker_unit.sv =====
// A taken word goes straight to its result when header handling is off or the frame is
// too short; otherwise the table is searched from entry 0, a found producer passes through
// a miss and a sum state, and a new producer is appended or a full table reported.
// One word in flight: the next word is taken in the cycle after the result is registered; the
// table is scanned one entry at a time, a read then a compare, through its registered read port.
// Reset (synchronous, active low) empties the table and sets header on, timestamps off.
module producer_sequence_gap_tracker_unit
    import pstg_pkg::*;
#(
    parameter int MAX_PRODUCERS = MAX_PRODUCERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // producer_id[15:0], sequence_req[31:16], epoch_seconds[63:32],
    // offset_nanoseconds[95:64], frame_bytes[111:96]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,
    // status[1:0], header_length[5:2], new_producer[6], slot[9:7],
    // frames_missed_now[25:10], missed_total[41:26], zero fill[47:42]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_index,
    input  logic         i_cfg_data
);

    localparam int IW = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
    localparam int CW = $clog2(MAX_PRODUCERS + 1);
    localparam logic [CW-1:0] USED_FULL = CW'(MAX_PRODUCERS);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_READ, S_CMP, S_MISS, S_SUM, S_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] total;
        logic [15:0] now;
        logic [2:0]  slot;
        logic        new_producer;
        logic [3:0]  hdr_len;
        logic [1:0]  status;
    } t_result;

    t_state      r_state, n_state;
    logic        r_hdr_en, n_hdr_en;
    logic        r_ts_en, n_ts_en;
    logic [CW-1:0] r_used, n_used;
    logic [IW-1:0] r_idx, n_idx;
    logic [15:0] r_pid, n_pid;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_eps, n_eps;
    logic [31:0] r_ons, n_ons;
    logic [15:0] r_len, n_len;
    logic [15:0] r_miss, n_miss;
    t_result     r_pend, n_pend;
    t_result     r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic        wr_en;
    logic [IW-1:0] wr_addr;
    t_entry      wr_data;
    t_entry      rd_data;
    logic        append;
    logic [16:0] sum;
    logic [15:0] need;

    pstg_table #(
        .MAX_PRODUCERS(MAX_PRODUCERS)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_hdr_en    = r_hdr_en;
        n_ts_en     = r_ts_en;
        n_used      = r_used;
        n_idx       = r_idx;
        n_pid       = r_pid;
        n_seq       = r_seq;
        n_eps       = r_eps;
        n_ons       = r_ons;
        n_len       = r_len;
        n_miss      = r_miss;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '{producer: r_pid, sequence_no: r_seq, missed: 16'd0,
                        epoch: r_eps, offset: r_ons};
        append      = 1'b0;
        sum         = {1'b0, rd_data.missed} + {1'b0, r_miss};
        need        = r_ts_en ? MIN_LEN_TS : MIN_LEN_BASIC;

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_HEADER_EN:    n_hdr_en = i_cfg_data;
                REG_TIMESTAMP_EN: n_ts_en  = i_cfg_data;
                default:          ;
            endcase
        end

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_pid   = s_tdata[15:0];
                    n_seq   = s_tdata[31:16];
                    n_eps   = r_ts_en ? s_tdata[63:32] : 32'd0;
                    n_ons   = r_ts_en ? s_tdata[95:64] : 32'd0;
                    n_len   = s_tdata[111:96];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx  = '0;
                n_pend = '0;
                if (!r_hdr_en) begin
                    n_pend.status = ST_OK;
                    n_state       = S_DONE;
                end else if (r_len < need) begin
                    n_pend.status = ST_TOO_SHORT;
                    n_state       = S_DONE;
                end else if (r_used == '0) begin
                    append = 1'b1;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rd_data.producer == r_pid) begin
                    n_state = S_MISS;
                end else if (CW'(r_idx) + CW'(1) == r_used) begin
                    if (r_used == USED_FULL) begin
                        n_pend        = '0;
                        n_pend.status = ST_TABLE_FULL;
                        n_state       = S_DONE;
                    end else begin
                        append = 1'b1;
                    end
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_READ;
                end
            end
            S_MISS: begin
                // gap wraps modulo 2^16, so a repeated sequence gives 0xFFFF
                n_miss  = r_seq - rd_data.sequence_no - 16'd1;
                n_state = S_SUM;
            end
            S_SUM: begin
                wr_en          = 1'b1;
                wr_addr        = r_idx;
                wr_data.missed = sum[16] ? SAT16 : sum[15:0];
                n_pend         = '{total: wr_data.missed, now: r_miss, slot: 3'(r_idx),
                                   new_producer: 1'b0, hdr_len: HDR_LEN, status: ST_OK};
                n_state        = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || m_tready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (append) begin
            wr_en   = 1'b1;
            wr_addr = r_used[IW-1:0];
            n_used  = r_used + CW'(1);
            n_pend  = '{total: 16'd0, now: 16'd0, slot: 3'(r_used),
                        new_producer: 1'b1, hdr_len: HDR_LEN, status: ST_OK};
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hdr_en    <= 1'b1;
            r_ts_en     <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hdr_en    <= n_hdr_en;
            r_ts_en     <= n_ts_en;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_pid  <= n_pid;
        r_seq  <= n_seq;
        r_eps  <= n_eps;
        r_ons  <= n_ons;
        r_len  <= n_len;
        r_miss <= n_miss;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out};

endmodule

// ===== rtl/pstg_table.sv =====
module pstg_table
    import pstg_pkg::*;
#(
    parameter int MAX_PRODUCERS = MAX_PRODUCERS_DEF,
    localparam int IW = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [MAX_PRODUCERS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/producer_sequence_gap_tracker_unit_tb.sv =====
`timescale 1ns / 100ps

module producer_sequence_gap_tracker_unit_tb;
    import pstg_pkg::*;

    localparam int N_PRODUCERS  = MAX_PRODUCERS_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 25;
    localparam int HOLD_TICKS   = 400;
    localparam int PHASE_ITEMS  = 330;

    typedef struct packed {
        logic [15:0] frame_bytes;
        logic [31:0] offset_nsec;
        logic [31:0] epoch_s;
        logic [15:0] sequence_req;
        logic [15:0] producer_id;
    } frame_t;

    typedef struct packed {
        logic [5:0]  fill;
        logic [15:0] missed_total;
        logic [15:0] missed_now;
        logic [2:0]  slot;
        logic        new_producer;
        logic [3:0]  header_length;
        logic [1:0]  status;
    } report_t;

    class gap_scoreboard;
        bit          header_on    = 1'b1;
        bit          timestamp_on = 1'b0;
        logic [15:0] tbl_producer [N_PRODUCERS];
        logic [15:0] tbl_sequence [N_PRODUCERS];
        logic [15:0] tbl_missed   [N_PRODUCERS];
        logic [31:0] tbl_epoch    [N_PRODUCERS];
        logic [31:0] tbl_offset   [N_PRODUCERS];
        int          used         = 0;
        report_t     expected_reports [$];
        int          mismatches   = 0;

        function void predict_report(frame_t f);
            report_t     r;
            logic [15:0] need;
            logic [15:0] miss;
            logic [16:0] sum;
            int          hit;
            bit          found;
            r     = '0;
            hit   = 0;
            found = 1'b0;
            miss  = '0;
            sum   = '0;
            if (header_on) begin
                need = timestamp_on ? MIN_LEN_TS : MIN_LEN_BASIC;
                if (f.frame_bytes < need) begin
                    r.status = ST_TOO_SHORT;
                end else begin
                    for (int i = 0; i < used; i++) begin
                        if (!found && tbl_producer[i] == f.producer_id) begin
                            found = 1'b1;
                            hit   = i;
                        end
                    end
                    if (!found && used >= N_PRODUCERS) begin
                        r.status = ST_TABLE_FULL;
                    end else begin
                        if (!found) begin
                            // append with a clean missed count
                            hit               = used;
                            tbl_producer[hit] = f.producer_id;
                            tbl_missed[hit]   = '0;
                            used++;
                            r.new_producer    = 1'b1;
                        end else begin
                            // gap wraps at 16 bits, so a repeat counts as a full wrap
                            miss = f.sequence_req - tbl_sequence[hit] - 16'd1;
                            sum  = tbl_missed[hit] + miss;
                            if (sum > SAT16) sum = SAT16;
                            tbl_missed[hit] = sum[15:0];
                        end
                        tbl_sequence[hit] = f.sequence_req;
                        tbl_epoch[hit]    = timestamp_on ? f.epoch_s : 32'd0;
                        tbl_offset[hit]   = timestamp_on ? f.offset_nsec : 32'd0;
                        r.status          = ST_OK;
                        r.header_length   = HDR_LEN;
                        r.slot            = hit[2:0];
                        r.missed_now      = miss;
                        r.missed_total    = sum[15:0];
                    end
                end
            end
            expected_reports.insert(expected_reports.size(), r);
        endfunction

        function void check_result(report_t got);
            report_t want;
            bit      bad;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = expected_reports.pop_front();
            bad  = (got.status !== want.status) ||
                   (got.header_length !== want.header_length) ||
                   (got.new_producer !== want.new_producer) ||
                   (got.slot !== want.slot) ||
                   (got.missed_now !== want.missed_now) ||
                   (got.missed_total !== want.missed_total) ||
                   (got.fill !== want.fill);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: want st=%0d hl=%0d np=%0d slot=%0d now=%0d tot=%0d",
                             want.status, want.header_length, want.new_producer,
                             want.slot, want.missed_now, want.missed_total);
                    $display("  got st=%0d hl=%0d np=%0d slot=%0d now=%0d tot=%0d f=%h",
                             got.status, got.header_length, got.new_producer,
                             got.slot, got.missed_now, got.missed_total, got.fill);
                end
            end
        endfunction
    endclass

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [47:0]  m_tdata;
    logic         i_cfg_wr_en = 1'b0;
    logic         i_cfg_index = REG_HEADER_EN;
    logic         i_cfg_data  = 1'b0;

    gap_scoreboard sb = new();

    int          cycle_count  = 0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    bit          hold_request = 1'b0;
    int          hold_left    = 0;
    logic [15:0] known_pid [N_PRODUCERS] = '{16'h0000, 16'hFFFF, 16'd1, 16'd2,
                                             16'd3, 16'd4, 16'd5, 16'd6};
    logic [15:0] next_seq  [N_PRODUCERS];

    producer_sequence_gap_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check each taken word, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_request) begin
            hold_left    = HOLD_TICKS;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic frame_t mk_frame(input logic [15:0] pid, input logic [15:0] seq,
                                        input logic [31:0] eps, input logic [31:0] ons,
                                        input logic [15:0] len);
        frame_t f;
        f.producer_id  = pid;
        f.sequence_req = seq;
        f.epoch_s      = eps;
        f.offset_nsec  = ons;
        f.frame_bytes  = len;
        return f;
    endfunction

    function automatic frame_t pick_frame();
        frame_t f;
        int     j;
        int     r;
        j = $urandom_range(N_PRODUCERS - 1);
        r = $urandom_range(99);
        // mostly in-order sequences, a few gaps, rare jumps and repeats
        if (r < 70)      f.sequence_req = next_seq[j];
        else if (r < 97) f.sequence_req = next_seq[j] + 16'($urandom_range(1, 40));
        else if (r < 99) f.sequence_req = 16'($urandom);
        else             f.sequence_req = next_seq[j] - 16'd1;
        if ($urandom_range(99) < 80) begin
            f.producer_id = known_pid[j];
            next_seq[j]   = f.sequence_req + 16'd1;
        end else begin
            f.producer_id = 16'($urandom);
        end
        f.epoch_s     = $urandom;
        f.offset_nsec = $urandom;
        f.frame_bytes = ($urandom_range(9) == 0) ? 16'($urandom_range(13))
                                                 : 16'($urandom_range(65535));
        return f;
    endfunction

    task automatic send_frame(input frame_t f);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.predict_report(f);
    endtask

    // drop valid and wait until every pending report is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_config(input logic hdr, input logic ts);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_HEADER_EN;
        i_cfg_data  <= hdr;
        @(posedge i_clk);
        sb.header_on = hdr;
        i_cfg_index <= REG_TIMESTAMP_EN;
        i_cfg_data  <= ts;
        @(posedge i_clk);
        sb.timestamp_on = ts;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        bit cfg_hdr [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        bit cfg_ts  [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 20;
        rx_idle_pct = 47;
        set_config(1'b1, 1'b0);
        // short frames, then a new producer and gap wrap, repeat and saturation
        send_frame(mk_frame(16'h0000, 16'h0000, '0, '0, 16'd0));
        send_frame(mk_frame(16'h0000, 16'h0000, '0, '0, 16'd3));
        send_frame(mk_frame(16'h0000, 16'hFFFF, '0, '0, 16'd4));
        send_frame(mk_frame(16'h0000, 16'h0000, '1, '1, 16'hFFFF));
        send_frame(mk_frame(16'h0000, 16'h0000, '0, '0, 16'd100));
        send_frame(mk_frame(16'h0000, 16'h0005, '0, '0, 16'd4));
        send_frame(mk_frame(16'hFFFF, 16'h1234, '1, '1, 16'd12));
        for (int i = 2; i < N_PRODUCERS; i++)
            send_frame(mk_frame(known_pid[i], 16'(16'h0100 * i), $urandom, $urandom, 16'd64));
        // table is full now
        send_frame(mk_frame(16'hABCD, 16'h0000, '0, '0, 16'd64));

        set_config(1'b1, 1'b1);
        send_frame(mk_frame(16'd1, 16'h0201, '0, '0, 16'd11));
        send_frame(mk_frame(16'd1, 16'h0201, '1, '1, 16'd12));
        send_frame(mk_frame(16'hFFFF, 16'h1235, '0, '0, 16'hFFFF));

        set_config(1'b0, 1'b1);
        send_frame(mk_frame(16'h5555, 16'h0000, '0, '0, 16'd0));
        send_frame(mk_frame(16'h0000, 16'hFFFF, '1, '1, 16'hFFFF));
        set_config(1'b0, 1'b0);
        send_frame(mk_frame(16'hABCD, 16'h0001, '0, '0, 16'd2));

        next_seq[0] = 16'h0006;
        next_seq[1] = 16'h1236;
        for (int i = 2; i < N_PRODUCERS; i++) next_seq[i] = 16'(16'h0100 * i + 1);
        next_seq[2] = 16'h0202;

        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            set_config(cfg_hdr[p], cfg_ts[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == 40) hold_request = 1'b1;
                if (p == 3 && n == 160) settle();
                send_frame(pick_frame());
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pstg_pkg.sv
rtl/pstg_table.sv
rtl/producer_sequence_gap_tracker_unit.sv
tb/producer_sequence_gap_tracker_unit_tb.sv
